FILE: rtl/pvrt_pkg.sv
// ----------------------------------------------------------------------------
// pvrt_pkg: shared definitions of the path vector route table
// Field widths, request codes, register indexes and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pvrt_pkg;

  localparam int unsigned NODES_DEF = 16;

  localparam int unsigned ID_W   = 4;
  localparam int unsigned COST_W = 16;
  localparam int unsigned ALEN_W = 4;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned PATH_W = 64;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned REQ_W  = 3;

  localparam logic [ID_W-1:0]   MY_ID_RST = 4'd0;
  localparam logic [COST_W-1:0] INF_RST   = 16'd999;

  localparam logic [REQ_W-1:0] REQ_RESET = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ROUTE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DIE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP  = 3'd4;

  localparam logic REG_MY_ID = 1'b0;
  localparam logic REG_INF   = 1'b1;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic route_wr;
    logic emit_rec;
    logic emit_empty;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             busy;
    logic             count_zero;
    logic             cur_filled;
    logic             cur_last;
  } status_t;

endpackage

FILE: rtl/pvrt_ifs.sv
// ----------------------------------------------------------------------------
// pvrt_ifs: word channels of the path vector route table
// Request channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface pvrt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  src_node;
  logic [15:0] link_cost;
  logic [3:0]  target_node;
  logic [15:0] adv_cost;
  logic [3:0]  adv_plen;
  logic [63:0] adv_path;
  logic        last_entry;

  modport source (output valid, req_type, src_node, link_cost, target_node, adv_cost,
                  adv_plen, adv_path, last_entry, input ready);
  modport sink (input valid, req_type, src_node, link_cost, target_node, adv_cost,
                adv_plen, adv_path, last_entry, output ready);
endinterface

interface pvrt_rsp_if;
  logic        valid;
  logic        ready;
  logic        entry_changed;
  logic        packet_changed;
  logic        record_valid;
  logic [3:0]  out_dest;
  logic [3:0]  out_hop;
  logic [15:0] out_cost;
  logic [4:0]  out_plen;
  logic [63:0] out_path;
  logic [4:0]  route_count;
  logic        last_result;

  modport source (output valid, entry_changed, packet_changed, record_valid, out_dest,
                  out_hop, out_cost, out_plen, out_path, route_count,
                  last_result, input ready);
  modport sink (input valid, entry_changed, packet_changed, record_valid, out_dest,
                out_hop, out_cost, out_plen, out_path, route_count,
                last_result, output ready);
endinterface

FILE: rtl/path_vector_route_table.sv
// A route word passes the capture, execute and route states; the route state registers its
// result word once the result register is free. A dump gives one result word per filled
// entry as the result side takes them; the scan walks one entry a cycle but waits on a
// filled entry while the previous result word is untaken. One request word at a time is
// taken, and a new word only when the controller is idle.
// Reset (rst_ni low, asynchronous): table empty, counters clear, registers at reset.
// ----------------------------------------------------------------------------
// path_vector_route_table: path vector routing table
// Keeps one route per destination node and merges advertised routes from
// neighbours, with table reset, neighbour add, neighbour death and dump.
// ----------------------------------------------------------------------------
module path_vector_route_table #(
  parameter int unsigned NODES = pvrt_pkg::NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pvrt_req_if.sink    req_i,
  pvrt_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration values seen by the datapath.
  logic [pvrt_pkg::ID_W-1:0]   my_id;
  logic [pvrt_pkg::COST_W-1:0] inf_cost;

  // Controller to datapath commands and the status fed back.
  pvrt_pkg::cmd_t    cmd;
  pvrt_pkg::status_t status;

  pvrt_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .my_id_o    (my_id),
    .inf_cost_o (inf_cost)
  );

  // The controller takes a new request word only when idle; the result word
  // sits in its own register, so the controller waits only when it must load
  // a new result word while the previous one is still untaken.
  pvrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pvrt_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .my_id_i          (my_id),
    .inf_cost_i       (inf_cost),
    .req_type_i       (req_i.req_type),
    .src_node_i       (req_i.src_node),
    .link_cost_i      (req_i.link_cost),
    .target_node_i    (req_i.target_node),
    .adv_cost_i       (req_i.adv_cost),
    .adv_plen_i       (req_i.adv_plen),
    .adv_path_i       (req_i.adv_path),
    .last_entry_i     (req_i.last_entry),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .entry_changed_o  (rsp_o.entry_changed),
    .packet_changed_o (rsp_o.packet_changed),
    .record_valid_o   (rsp_o.record_valid),
    .out_dest_o       (rsp_o.out_dest),
    .out_hop_o        (rsp_o.out_hop),
    .out_cost_o       (rsp_o.out_cost),
    .out_plen_o       (rsp_o.out_plen),
    .out_path_o       (rsp_o.out_path),
    .route_count_o    (rsp_o.route_count),
    .last_result_o    (rsp_o.last_result)
  );

endmodule

FILE: rtl/pvrt_regs.sv
// ----------------------------------------------------------------------------
// pvrt_regs: configuration registers
// APB-style write and read of the node id and the infinity cost.
// ----------------------------------------------------------------------------
module pvrt_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [pvrt_pkg::ID_W-1:0]    my_id_o,
  output logic [pvrt_pkg::COST_W-1:0]  inf_cost_o
);

  logic [pvrt_pkg::ID_W-1:0]   my_id_q, my_id_d;
  logic [pvrt_pkg::COST_W-1:0] inf_q, inf_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    my_id_d = my_id_q;
    inf_d   = inf_q;
    if (wr_en) begin
      unique case (paddr[2])
        pvrt_pkg::REG_MY_ID: my_id_d = pwdata[pvrt_pkg::ID_W-1:0];
        pvrt_pkg::REG_INF:   inf_d   = pwdata[pvrt_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pvrt_pkg::REG_MY_ID: prdata = {28'd0, my_id_q};
      pvrt_pkg::REG_INF:   prdata = {16'd0, inf_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q <= pvrt_pkg::MY_ID_RST;
      inf_q   <= pvrt_pkg::INF_RST;
    end else begin
      my_id_q <= my_id_d;
      inf_q   <= inf_d;
    end
  end

  assign my_id_o    = my_id_q;
  assign inf_cost_o = inf_q;

endmodule

FILE: rtl/pvrt_dp.sv
// ----------------------------------------------------------------------------
// pvrt_dp: route table datapath
// Holds the table, the request word, the cost stage and the result register.
// ----------------------------------------------------------------------------
module pvrt_dp #(
  parameter int unsigned NODES = pvrt_pkg::NODES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvrt_pkg::cmd_t                cmd_i,
  output pvrt_pkg::status_t             status_o,
  input  logic [pvrt_pkg::ID_W-1:0]     my_id_i,
  input  logic [pvrt_pkg::COST_W-1:0]   inf_cost_i,
  input  logic [2:0]                    req_type_i,
  input  logic [3:0]                    src_node_i,
  input  logic [15:0]                   link_cost_i,
  input  logic [3:0]                    target_node_i,
  input  logic [15:0]                   adv_cost_i,
  input  logic [3:0]                    adv_plen_i,
  input  logic [63:0]                   adv_path_i,
  input  logic                          last_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          entry_changed_o,
  output logic                          packet_changed_o,
  output logic                          record_valid_o,
  output logic [3:0]                    out_dest_o,
  output logic [3:0]                    out_hop_o,
  output logic [15:0]                   out_cost_o,
  output logic [4:0]                    out_plen_o,
  output logic [63:0]                   out_path_o,
  output logic [4:0]                    route_count_o,
  output logic                          last_result_o
);

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned ID_W = pvrt_pkg::ID_W;
  localparam int unsigned COST_W = pvrt_pkg::COST_W;
  localparam int unsigned LEN_W = pvrt_pkg::LEN_W;
  localparam int unsigned PATH_W = pvrt_pkg::PATH_W;
  localparam int unsigned CNT_W = pvrt_pkg::CNT_W;

  // Request word.
  logic [2:0]        req_q;
  logic [ID_W-1:0]   sender_q, tgt_q;
  logic [COST_W-1:0] link_q, acost_q;
  logic [3:0]        alen_q;
  logic [PATH_W-1:0] apath_q, apath_m;
  logic              last_q;

  // Table.
  logic [NODES-1:0]  filled_q, filled_d;
  logic [ID_W-1:0]   hop_q [NODES];
  logic [ID_W-1:0]   hop_d [NODES];
  logic [COST_W-1:0] cost_q [NODES];
  logic [COST_W-1:0] cost_d [NODES];
  logic [LEN_W-1:0]  len_q [NODES];
  logic [LEN_W-1:0]  len_d [NODES];
  logic [PATH_W-1:0] path_q [NODES];
  logic [PATH_W-1:0] path_d [NODES];
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pkt_q, pkt_d;
  logic [IW-1:0]     idx_q, idx_d;

  // Cost stage.
  logic [COST_W-1:0] ncost_q, ncost_d;
  logic              inpath_q, inpath_d;

  // Result register.
  logic              ov_q, ov_d;
  logic              o_chg_q, o_chg_d, o_pkt_q, o_pkt_d, o_rec_q, o_rec_d, o_last_q, o_last_d;
  logic [3:0]        o_dest_q, o_dest_d, o_hop_q, o_hop_d;
  logic [15:0]       o_cost_q, o_cost_d;
  logic [4:0]        o_len_q, o_len_d, o_cnt_q, o_cnt_d;
  logic [63:0]       o_path_q, o_path_d;
  logic              o_load;

  logic              tgt_ok, me_ok, take, later, differs;
  logic [IW-1:0]     tidx, me_idx;
  logic [COST_W:0]   sum;
  logic [PATH_W-1:0] npath;
  logic [LEN_W-1:0]  nlen;
  logic [CNT_W-1:0]  cnt_after;

  assign tgt_ok = {1'b0, tgt_q} < 5'(NODES);
  assign me_ok  = {1'b0, my_id_i} < 5'(NODES);
  assign tidx   = tgt_q[IW-1:0];
  assign me_idx = my_id_i[IW-1:0];

  // Only the nibbles inside the advertised length are kept.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      apath_m[4*k +: 4] = (5'(k) < {1'b0, adv_plen_i}) ? adv_path_i[4*k +: 4] : 4'd0;
    end
  end

  assign sum = {1'b0, acost_q} + {1'b0, link_q};

  always_comb begin
    inpath_d = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if ((5'(k) < {1'b0, alen_q}) && (apath_q[4*k +: 4] == my_id_i)) inpath_d = 1'b1;
    end
  end

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < NODES; j++) begin
      if ((IW'(j) > idx_q) && filled_q[j]) later = 1'b1;
    end
  end

  assign npath   = {apath_q[PATH_W-5:0], my_id_i};
  assign nlen    = {1'b0, alen_q} + 5'd1;
  assign differs = (cost_q[idx_q] != ncost_q) || (len_q[idx_q] != nlen) ||
                   (path_q[idx_q] != npath);
  assign take    = tgt_ok && (!filled_q[idx_q] ||
                   ((sender_q == hop_q[idx_q]) && differs) ||
                   ((ncost_q < cost_q[idx_q]) && !inpath_q));
  assign cnt_after = count_q + CNT_W'(take && !filled_q[idx_q]);

  always_comb begin
    filled_d = filled_q;
    hop_d    = hop_q;
    cost_d   = cost_q;
    len_d    = len_q;
    path_d   = path_q;
    count_d  = count_q;
    pkt_d    = pkt_q;
    idx_d    = idx_q;
    ncost_d  = ncost_q;
    o_load   = 1'b0;
    o_chg_d  = 1'b0;
    o_pkt_d  = 1'b0;
    o_rec_d  = 1'b0;
    o_dest_d = '0;
    o_hop_d  = '0;
    o_cost_d = '0;
    o_len_d  = '0;
    o_path_d = '0;
    o_cnt_d  = count_q;
    o_last_d = 1'b1;

    if (cmd_i.exec) begin
      unique case (req_q)
        pvrt_pkg::REQ_RESET: begin
          filled_d = '0;
          count_d  = '0;
          pkt_d    = 1'b0;
          if (me_ok) begin
            filled_d[me_idx] = 1'b1;
            hop_d[me_idx]    = my_id_i;
            cost_d[me_idx]   = '0;
            len_d[me_idx]    = 5'd1;
            path_d[me_idx]   = {60'd0, my_id_i};
            count_d          = 5'd1;
          end
        end
        pvrt_pkg::REQ_ADD: begin
          if (tgt_ok) begin
            count_d        = count_q + CNT_W'(!filled_q[tidx]);
            filled_d[tidx] = 1'b1;
            hop_d[tidx]    = tgt_q;
            cost_d[tidx]   = link_q;
            len_d[tidx]    = 5'd2;
            path_d[tidx]   = {56'd0, tgt_q, my_id_i};
          end
        end
        pvrt_pkg::REQ_ROUTE: begin
          ncost_d = (sum > {1'b0, inf_cost_i}) ? inf_cost_i : sum[COST_W-1:0];
          idx_d   = tidx;
        end
        pvrt_pkg::REQ_DIE: begin
          for (int i = 0; i < NODES; i++) begin
            if (filled_q[i] && (hop_q[i] == tgt_q)) cost_d[i] = inf_cost_i;
          end
        end
        pvrt_pkg::REQ_DUMP: idx_d = '0;
        default: ;
      endcase
    end

    if (cmd_i.route_wr) begin
      if (take) begin
        filled_d[idx_q] = 1'b1;
        hop_d[idx_q]    = sender_q;
        cost_d[idx_q]   = ncost_q;
        len_d[idx_q]    = nlen;
        path_d[idx_q]   = npath;
      end
      count_d  = cnt_after;
      pkt_d    = last_q ? 1'b0 : (pkt_q || take);
      o_load   = 1'b1;
      o_chg_d  = take;
      o_pkt_d  = last_q && (pkt_q || take);
      o_cnt_d  = cnt_after;
    end

    if (cmd_i.emit_rec) begin
      o_load   = 1'b1;
      o_rec_d  = 1'b1;
      o_dest_d = ID_W'(idx_q);
      o_hop_d  = hop_q[idx_q];
      o_cost_d = cost_q[idx_q];
      o_len_d  = len_q[idx_q];
      o_path_d = path_q[idx_q];
      o_last_d = !later;
    end

    if (cmd_i.emit_empty) o_load = 1'b1;

    if (cmd_i.idx_inc) idx_d = idx_q + 1'b1;
  end

  always_comb begin
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    if (o_load) ov_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      count_q  <= '0;
      pkt_q    <= 1'b0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      filled_q <= filled_d;
      count_q  <= count_d;
      pkt_q    <= pkt_d;
      idx_q    <= idx_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hop_q    <= hop_d;
    cost_q   <= cost_d;
    len_q    <= len_d;
    path_q   <= path_d;
    ncost_q  <= ncost_d;
    if (cmd_i.exec) inpath_q <= inpath_d;
    if (cmd_i.load_in) begin
      req_q    <= req_type_i;
      sender_q <= src_node_i;
      link_q   <= link_cost_i;
      tgt_q    <= target_node_i;
      acost_q  <= adv_cost_i;
      alen_q   <= adv_plen_i;
      apath_q  <= apath_m;
      last_q   <= last_entry_i;
    end
    if (o_load) begin
      o_chg_q  <= o_chg_d;
      o_pkt_q  <= o_pkt_d;
      o_rec_q  <= o_rec_d;
      o_dest_q <= o_dest_d;
      o_hop_q  <= o_hop_d;
      o_cost_q <= o_cost_d;
      o_len_q  <= o_len_d;
      o_path_q <= o_path_d;
      o_cnt_q  <= o_cnt_d;
      o_last_q <= o_last_d;
    end
  end

  // The result register may be reloaded in the cycle its word is taken.
  assign status_o.req        = req_q;
  assign status_o.busy       = ov_q && !out_ready_i;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.cur_filled = filled_q[idx_q];
  assign status_o.cur_last   = !later;

  assign out_valid_o      = ov_q;
  assign entry_changed_o  = o_chg_q;
  assign packet_changed_o = o_pkt_q;
  assign record_valid_o   = o_rec_q;
  assign out_dest_o       = o_dest_q;
  assign out_hop_o        = o_hop_q;
  assign out_cost_o       = o_cost_q;
  assign out_plen_o       = o_len_q;
  assign out_path_o       = o_path_q;
  assign route_count_o    = o_cnt_q;
  assign last_result_o    = o_last_q;

endmodule

FILE: rtl/pvrt_ctrl.sv
// ----------------------------------------------------------------------------
// pvrt_ctrl: route table controller
// Sequences each request word: capture, execute, route merge and dump scan.
// ----------------------------------------------------------------------------
module pvrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pvrt_pkg::status_t status_i,
  output pvrt_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_ROUTE = 4'b0100,
    S_DUMP  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.req == pvrt_pkg::REQ_ROUTE) state_d = S_ROUTE;
        else if (status_i.req == pvrt_pkg::REQ_DUMP) state_d = S_DUMP;
        else state_d = S_IDLE;
      end
      S_ROUTE: begin
        if (!status_i.busy) begin
          cmd_o.route_wr = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DUMP: begin
        if (status_i.count_zero) begin
          if (!status_i.busy) begin
            cmd_o.emit_empty = 1'b1;
            state_d          = S_IDLE;
          end
        end else if (status_i.cur_filled) begin
          if (!status_i.busy) begin
            cmd_o.emit_rec = 1'b1;
            if (status_i.cur_last) state_d = S_IDLE;
            else cmd_o.idx_inc = 1'b1;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
